// ===== sv/sjtc_pkg.sv =====
// shared types, constants and the shift-jis to jis conversion for the text cursor unit
`timescale 1ns / 1ps

package sjtc_pkg;

   localparam int COORD_W     = 12;
   localparam int CURSOR_W    = 13;
   localparam int CELL_W      = 16;
   localparam int SIZE_W      = 8;
   localparam int CODE_W      = 16;
   localparam int BYTE_W      = 8;
   localparam int MODE_W      = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CURSOR_W-1:0] CURSOR_MAX = '1;

   localparam logic [COORD_W-1:0] RST_WIN_LEFT   = 12'd0;
   localparam logic [COORD_W-1:0] RST_WIN_TOP    = 12'd0;
   localparam logic [COORD_W-1:0] RST_WIN_WIDTH  = 12'd320;
   localparam logic [COORD_W-1:0] RST_WIN_HEIGHT = 12'd240;
   localparam logic [CELL_W-1:0]  RST_ASCII_CELL = 16'h0808;
   localparam logic [CELL_W-1:0]  RST_KANJI_CELL = 16'h1010;
   localparam logic               RST_MULTI_LINE = 1'b1;
   localparam logic [MODE_W-1:0]  RST_DRAW_MODE  = 2'd0;

   localparam logic [BYTE_W-1:0] ASCII_NEWLINE = 8'h0a;

   localparam logic [0:0] OP_TEXT = 1'b0;
   localparam logic [0:0] OP_HOME = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WIN_LEFT   = 3'd0,
      CSR_WIN_TOP    = 3'd1,
      CSR_WIN_WIDTH  = 3'd2,
      CSR_WIN_HEIGHT = 3'd3,
      CSR_ASCII_CELL = 3'd4,
      CSR_KANJI_CELL = 3'd5,
      CSR_MULTI_LINE = 3'd6,
      CSR_DRAW_MODE  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] win_left;
      logic [COORD_W-1:0] win_top;
      logic [COORD_W-1:0] win_width;
      logic [COORD_W-1:0] win_height;
      logic [CELL_W-1:0]  ascii_cell;
      logic [CELL_W-1:0]  kanji_cell;
      logic               multi_line;
      logic [MODE_W-1:0]  draw_mode;
   } cfg_type;

   // classified character or command handed from front to back
   typedef struct packed {
      logic              home;
      logic              kanji;
      logic [CODE_W-1:0] code;
   } item_type;

   function automatic logic [CODE_W-1:0] sjis_to_jis(input logic [BYTE_W-1:0] lead,
                                                     input logic [BYTE_W-1:0] trail);
      logic [BYTE_W-1:0] hi;
      logic [BYTE_W-1:0] hi_off;
      logic [BYTE_W-1:0] lo;
      logic              second_row;
      logic [CODE_W-1:0] lo_code;
      logic [BYTE_W-1:0] row;
      hi         = (lead >= 8'he0) ? lead - 8'h40 : lead;
      hi_off     = hi - 8'h81;
      lo         = (trail >= 8'h80) ? trail - 8'h01 : trail;
      second_row = (lo >= 8'h9e);
      // low trail bytes wrap below zero and set the whole upper byte
      lo_code    = second_row ? {8'h00, lo - 8'h9e} : {8'h00, lo} - 16'h0040;
      row        = {hi_off[BYTE_W-2:0], second_row};
      return ({row, 8'h00} | lo_code) + 16'h2121;
   endfunction

endpackage

// ===== sv/sjtc_channels.sv =====
// handshake channel interfaces for requests, draw commands and register writes
`timescale 1ns / 1ps

interface sjtc_req_if import sjtc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              op;
   logic [BYTE_W-1:0] text_byte;

   modport source (output valid, output op, output text_byte, input ready);
   modport sink   (input valid, input op, input text_byte, output ready);
endinterface

interface sjtc_rsp_if import sjtc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] pos_x;
   logic [COORD_W-1:0] pos_y;
   logic [SIZE_W-1:0]  cell_width;
   logic [SIZE_W-1:0]  cell_height;
   logic [CODE_W-1:0]  char_code;
   logic               font_select;
   logic [MODE_W-1:0]  mode;

   modport source (output valid, output pos_x, output pos_y, output cell_width,
                   output cell_height, output char_code, output font_select,
                   output mode, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input cell_width,
                   input cell_height, input char_code, input font_select,
                   input mode, output ready);
endinterface

interface sjtc_csr_if import sjtc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== sv/sjtc_front.sv =====
// front end: lead byte tracking, kanji conversion and item classification
`timescale 1ns / 1ps

module sjtc_front import sjtc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   sjtc_req_if.sink  req_bus,
   output logic      push,
   output item_type  push_item,
   input  logic      push_ready
);

   logic              lead_pending_ff, lead_pending_in;
   logic [BYTE_W-1:0] lead_byte_ff, lead_byte_in;
   logic              accept;
   logic              is_lead;
   logic [3:0]        column;

   assign req_bus.ready = push_ready;
   assign accept        = req_bus.valid && push_ready;
   assign column        = req_bus.text_byte[BYTE_W-1 -: 4];

   always_comb begin
      unique case (column) inside
         4'h8, 4'h9, 4'he, 4'hf: is_lead = 1'b1;
         default:                is_lead = 1'b0;
      endcase
   end

   always_comb begin
      lead_pending_in = lead_pending_ff;
      lead_byte_in    = lead_byte_ff;
      push            = 1'b0;
      push_item.home  = 1'b0;
      push_item.kanji = 1'b0;
      push_item.code  = {{(CODE_W-BYTE_W){1'b0}}, req_bus.text_byte};
      if (accept) begin
         if (req_bus.op == OP_HOME) begin
            lead_pending_in = 1'b0;
            lead_byte_in    = '0;
            push            = 1'b1;
            push_item.home  = 1'b1;
         end else if (req_bus.text_byte == '0) begin
            lead_pending_in = 1'b0;
            lead_byte_in    = '0;
         end else if (!lead_pending_ff && is_lead) begin
            lead_pending_in = 1'b1;
            lead_byte_in    = req_bus.text_byte;
         end else if (lead_pending_ff) begin
            lead_pending_in = 1'b0;
            lead_byte_in    = '0;
            push            = 1'b1;
            push_item.kanji = 1'b1;
            push_item.code  = sjis_to_jis(lead_byte_ff, req_bus.text_byte);
         end else begin
            push            = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_pending_ff <= 1'b0;
         lead_byte_ff    <= '0;
      end else begin
         lead_pending_ff <= lead_pending_in;
         lead_byte_ff    <= lead_byte_in;
      end
   end

endmodule

// ===== sv/sjtc_queue.sv =====
// short fifo between the classifier and the cursor back end
`timescale 1ns / 1ps

module sjtc_queue import sjtc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     push_ready,
   output logic     pop_valid,
   output item_type pop_item,
   input  logic     pop
);

   item_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;

   localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QUEUE_CNT_W-1:0] CNT_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef ASSERT_OFF
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != CNT_FULL))
      else $error("queue written while full");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count lost a transaction");
`endif

endmodule

// ===== sv/sjtc_back.sv =====
// back end: cursor placement, wrap and bottom checks, draw command register
`timescale 1ns / 1ps

module sjtc_back import sjtc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      pop_valid,
   input  item_type  pop_item,
   output logic      pop,
   sjtc_rsp_if.source rsp_bus
);

   logic [CURSOR_W-1:0] cursor_x_ff, cursor_x_in;
   logic [CURSOR_W-1:0] cursor_y_ff, cursor_y_in;
   logic                out_valid_ff, out_valid_in;
   logic [COORD_W-1:0]  pos_x_ff, pos_y_ff;
   logic [SIZE_W-1:0]   width_ff, height_ff;
   logic [CODE_W-1:0]   code_ff;
   logic                font_ff;
   logic [MODE_W-1:0]   mode_ff;

   logic [CELL_W-1:0]   glyph_cell;
   logic [SIZE_W-1:0]   w;
   logic [SIZE_W-1:0]   h;
   logic [CURSOR_W:0]   x_end;
   logic [CURSOR_W-1:0] right_edge;
   logic [CURSOR_W-1:0] bottom_edge;
   logic [CURSOR_W:0]   y_step;
   logic                wrap;
   logic [CURSOR_W-1:0] x_place, y_place;
   logic [CURSOR_W:0]   y_end;
   logic                no_font, drop_wrap, below;
   logic                emit;

   assign pop = pop_valid && (!out_valid_ff || rsp_bus.ready);

   assign glyph_cell  = pop_item.kanji ? cfg.kanji_cell : cfg.ascii_cell;
   assign w           = glyph_cell[SIZE_W-1:0];
   assign h           = glyph_cell[CELL_W-1 -: SIZE_W];
   assign no_font     = (glyph_cell == '0);
   assign x_end       = {1'b0, cursor_x_ff} + {{(CURSOR_W+1-SIZE_W){1'b0}}, w};
   assign right_edge  = {1'b0, cfg.win_left} + {1'b0, cfg.win_width};
   assign bottom_edge = {1'b0, cfg.win_top} + {1'b0, cfg.win_height};
   assign wrap        = (!pop_item.kanji && pop_item.code == {8'h00, ASCII_NEWLINE})
                        || (x_end > {1'b0, right_edge});
   assign drop_wrap   = wrap && !cfg.multi_line;
   assign y_step      = {1'b0, cursor_y_ff} + {{(CURSOR_W+1-SIZE_W){1'b0}}, h};

   // cursor y saturates instead of wrapping
   assign x_place = wrap ? {1'b0, cfg.win_left} : cursor_x_ff;
   assign y_place = wrap ? (y_step[CURSOR_W] ? CURSOR_MAX : y_step[CURSOR_W-1:0])
                         : cursor_y_ff;
   assign y_end   = {1'b0, y_place} + {{(CURSOR_W+1-SIZE_W){1'b0}}, h};
   assign below   = (y_end > {1'b0, bottom_edge});

   assign emit = pop && !pop_item.home && !no_font && !drop_wrap && !below;

   always_comb begin
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      if (pop) begin
         if (pop_item.home) begin
            cursor_x_in = {1'b0, cfg.win_left};
            cursor_y_in = {1'b0, cfg.win_top};
         end else if (!no_font && !drop_wrap) begin
            // a wrap stays in effect even when the character falls off the bottom
            cursor_x_in = x_place;
            cursor_y_in = y_place;
            if (!below) begin
               cursor_x_in = x_place + {{(CURSOR_W-SIZE_W){1'b0}}, w};
            end
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff  <= '0;
         cursor_y_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         pos_x_ff  <= x_place[COORD_W-1:0];
         pos_y_ff  <= y_place[COORD_W-1:0];
         width_ff  <= w;
         height_ff <= h;
         code_ff   <= pop_item.code;
         font_ff   <= pop_item.kanji;
         mode_ff   <= cfg.draw_mode;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.pos_x       = pos_x_ff;
   assign rsp_bus.pos_y       = pos_y_ff;
   assign rsp_bus.cell_width  = width_ff;
   assign rsp_bus.cell_height = height_ff;
   assign rsp_bus.char_code   = code_ff;
   assign rsp_bus.font_select = font_ff;
   assign rsp_bus.mode        = mode_ff;

`ifndef ASSERT_OFF
   a_home_moves_cursor: assert property (@(posedge clock) disable iff (reset)
      (pop && pop_item.home) |=> (cursor_x_ff == {1'b0, $past(cfg.win_left)}
                                  && cursor_y_ff == {1'b0, $past(cfg.win_top)}))
      else $error("home did not return cursor to window origin");

   a_result_from_pop: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(pop && !pop_item.home))
      else $error("draw command appeared without a character");
`endif

endmodule

// ===== sv/sjis_text_layout_cursor_unit.sv =====
// top level: register file, front classifier, queue and cursor back end
// the item for an accepted byte is written to the queue, then to the draw command register, before rsp
// throughput: one byte per cycle while the queue has room, set by the cursor update in the back end
// the two-entry queue lets the byte input keep flowing while a command waits on rsp
// reset (synchronous, active high) clears cursor, lead state and queue, loads register defaults
`timescale 1ns / 1ps

module sjis_text_layout_cursor_unit import sjtc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   sjtc_req_if.sink   req_bus,
   sjtc_rsp_if.source rsp_bus,
   sjtc_csr_if.sink   csr_bus
);

   cfg_type  cfg_ff, cfg_in;
   logic     push, push_ready;
   item_type push_item;
   logic     pop_valid, pop;
   item_type pop_item;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_WIN_LEFT:   cfg_in.win_left   = csr_bus.wdata[COORD_W-1:0];
            CSR_WIN_TOP:    cfg_in.win_top    = csr_bus.wdata[COORD_W-1:0];
            CSR_WIN_WIDTH:  cfg_in.win_width  = csr_bus.wdata[COORD_W-1:0];
            CSR_WIN_HEIGHT: cfg_in.win_height = csr_bus.wdata[COORD_W-1:0];
            CSR_ASCII_CELL: cfg_in.ascii_cell = csr_bus.wdata[CELL_W-1:0];
            CSR_KANJI_CELL: cfg_in.kanji_cell = csr_bus.wdata[CELL_W-1:0];
            CSR_MULTI_LINE: cfg_in.multi_line = csr_bus.wdata[0];
            CSR_DRAW_MODE:  cfg_in.draw_mode  = csr_bus.wdata[MODE_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.win_left   <= RST_WIN_LEFT;
         cfg_ff.win_top    <= RST_WIN_TOP;
         cfg_ff.win_width  <= RST_WIN_WIDTH;
         cfg_ff.win_height <= RST_WIN_HEIGHT;
         cfg_ff.ascii_cell <= RST_ASCII_CELL;
         cfg_ff.kanji_cell <= RST_KANJI_CELL;
         cfg_ff.multi_line <= RST_MULTI_LINE;
         cfg_ff.draw_mode  <= RST_DRAW_MODE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sjtc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push       (push),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   sjtc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop        (pop)
   );

   sjtc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .pop       (pop),
      .rsp_bus   (rsp_bus)
   );

endmodule
